[design/ple_pkg.sv]
// Package: shared types, codes and defaults for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 16;
  localparam int unsigned ELEM_WIDTH_DEFAULT = 32;

  localparam logic [2:0] OP_ADD_FRONT = 3'd0;
  localparam logic [2:0] OP_ADD_REAR  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_REAR  = 3'd3;
  localparam logic [2:0] OP_INS_POS   = 3'd4;
  localparam logic [2:0] OP_REM_POS   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  position;
    logic [31:0] new_element;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] removed_element;
    logic [4:0]  element_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic put;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic eval_ins;
    logic eval_rem;
    logic eval_move;
    logic ins;
    logic last;
    logic out_free;
  } sts_t;

endpackage

[design/positional_list_engine.sv]
// Top level of the positional list engine: controller, datapath and element RAM.
`timescale 1ns / 1ps
// Bounded ordered list of up to DEPTH elements held front to rear in one RAM.
// One request is worked at a time, and the next is accepted while the previous
// result waits in the output register. A request that fails its checks goes
// straight to the result; a removal moves the elements behind the removed place
// one forward; an insert moves those behind its place one back, then writes the
// new element. Elements move one per cycle through the RAM's single read and
// single write port. The RAM needs no clearing after reset.
module positional_list_engine #(
  parameter int unsigned DEPTH      = ple_pkg::DEPTH_DEFAULT,
  parameter int unsigned ELEM_WIDTH = ple_pkg::ELEM_WIDTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ple_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ple_pkg::rsp_t out_data_o
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ple_dp #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/ple_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/ple_ctrl.sv]
// Controller: sequences accept, evaluation, element moves and result delivery.
`timescale 1ns / 1ps
module ple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_MOVE   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_PUT    = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.eval_rem || (sts_i.eval_ins && sts_i.eval_move)) begin
          state_d = S_MOVE;
        end else if (sts_i.eval_ins) begin
          state_d = S_PUT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MOVE: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = sts_i.ins ? S_PUT : S_FINISH;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/ple_dp.sv]
// Datapath: request register, count, element RAM, move pointers and result register.
`timescale 1ns / 1ps
module ple_dp #(
  parameter int unsigned DEPTH      = ple_pkg::DEPTH_DEFAULT,
  parameter int unsigned ELEM_WIDTH = ple_pkg::ELEM_WIDTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ple_pkg::req_t in_data_i,
  input  ple_pkg::cmd_t cmd_i,
  output ple_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ple_pkg::rsp_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = ((CW > 5) ? CW : 5) + 1;
  localparam int unsigned XW = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;

  ple_pkg::req_t req_q;
  logic [CW-1:0] count_q, count_d;

  // evaluation
  logic [1:0]    ev_status;
  logic          ev_ins, ev_rem;
  logic [MW-1:0] ev_idx, posx, cntx;
  logic          full;

  logic [1:0]    status_q;
  logic          ins_q, rem_q, first_q;
  logic [AW-1:0] idx_q, ptr_q, end_q;

  // read pipeline
  logic          pend_q, pend_first_q;
  logic [AW-1:0] pend_addr_q;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [ELEM_WIDTH-1:0] wdata, rdata, removed_q, new_elem;
  logic [XW-1:0]         rem_ext;

  logic                  out_valid_q;
  ple_pkg::rsp_t         out_q;

  assign posx = MW'(req_q.position);
  assign cntx = MW'(count_q);
  assign full = (cntx >= MW'(DEPTH));

  always_comb begin
    ev_status = ple_pkg::ST_OK;
    ev_ins    = 1'b0;
    ev_rem    = 1'b0;
    ev_idx    = '0;
    case (req_q.op)
      ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_REAR: begin
        if (full) begin
          ev_status = ple_pkg::ST_FULL;
        end else begin
          ev_ins = 1'b1;
          ev_idx = (req_q.op == ple_pkg::OP_ADD_FRONT) ? '0 : cntx;
        end
      end
      ple_pkg::OP_REM_FRONT, ple_pkg::OP_REM_REAR: begin
        if (cntx == '0) begin
          ev_status = ple_pkg::ST_UNDERFLOW;
        end else begin
          ev_rem = 1'b1;
          ev_idx = (req_q.op == ple_pkg::OP_REM_FRONT) ? '0 : cntx - MW'(1);
        end
      end
      ple_pkg::OP_INS_POS: begin
        if (posx == '0 || posx > cntx + MW'(1)) begin
          ev_status = ple_pkg::ST_RANGE;
        end else if (full) begin
          ev_status = ple_pkg::ST_FULL;
        end else begin
          ev_ins = 1'b1;
          ev_idx = posx - MW'(1);
        end
      end
      ple_pkg::OP_REM_POS: begin
        if (posx == '0 || posx > cntx) begin
          ev_status = ple_pkg::ST_RANGE;
        end else begin
          ev_rem = 1'b1;
          ev_idx = posx - MW'(1);
        end
      end
      default: begin
        ev_status = ple_pkg::ST_OK;
      end
    endcase
  end

  assign sts_o.eval_ins  = ev_ins;
  assign sts_o.eval_rem  = ev_rem;
  assign sts_o.eval_move = (ev_idx != cntx);
  assign sts_o.ins       = ins_q;
  assign sts_o.last      = (ptr_q == end_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      status_q <= ev_status;
      ins_q    <= ev_ins;
      rem_q    <= ev_rem;
      first_q  <= 1'b1;
      idx_q    <= ev_idx[AW-1:0];
      ptr_q    <= ev_ins ? AW'(cntx - MW'(1)) : ev_idx[AW-1:0];
      end_q    <= ev_ins ? ev_idx[AW-1:0] : AW'(cntx - MW'(1));
    end else if (cmd_i.step) begin
      first_q <= 1'b0;
      ptr_q   <= ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end
    pend_first_q <= first_q;
    pend_addr_q  <= ptr_q;
    if (pend_q && pend_first_q && rem_q) begin
      removed_q <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.step;
    end
  end

  assign new_elem = ELEM_WIDTH'(req_q.new_element);

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_q;
    wdata = rdata;
    if (cmd_i.put) begin
      we    = 1'b1;
      waddr = idx_q;
      wdata = new_elem;
    end else if (pend_q) begin
      if (ins_q) begin
        we    = 1'b1;
        waddr = pend_addr_q + AW'(1);
      end else if (!pend_first_q) begin
        we    = 1'b1;
        waddr = pend_addr_q - AW'(1);
      end
    end
  end

  ple_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.step),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign rem_ext = XW'(removed_q);

  always_comb begin
    count_d = count_q;
    if (ins_q) begin
      count_d = count_q + CW'(1);
    end else if (rem_q) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.status          <= status_q;
      out_q.removed_element <= rem_q ? rem_ext[31:0] : 32'd0;
      out_q.element_count   <= 5'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[tb/ple_list_checker.sv]
// Checker for the positional list engine: predicts each result word and compares.
`timescale 1ns / 1ps
module ple_list_checker #(
  parameter int unsigned DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  ple_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ple_pkg::rsp_t out_data_i,
  output int unsigned   mismatches_o,
  output int unsigned   pending_o,
  output int unsigned   list_len_o,
  output int unsigned   words_o,
  output int unsigned   full_hits_o,
  output int unsigned   underflow_hits_o,
  output int unsigned   range_hits_o
);

  logic [31:0]   shadow_list [DEPTH];
  int unsigned   held;
  int unsigned   mismatches;
  int unsigned   words;
  int unsigned   full_hits;
  int unsigned   underflow_hits;
  int unsigned   range_hits;
  ple_pkg::rsp_t expected_rsp[$];
  ple_pkg::rsp_t want;

  function automatic void insert_at(input int unsigned slot, input logic [31:0] value);
    for (int k = held; k > slot; k--) shadow_list[k] = shadow_list[k-1];
    shadow_list[slot] = value;
    held++;
  endfunction

  function automatic logic [31:0] take_from(input int unsigned slot);
    logic [31:0] value;
    value = shadow_list[slot];
    for (int k = slot; k + 1 < held; k++) shadow_list[k] = shadow_list[k+1];
    held--;
    return value;
  endfunction

  function automatic ple_pkg::rsp_t apply_request(input ple_pkg::req_t r);
    ple_pkg::rsp_t rsp;
    rsp = '0;
    rsp.status = ple_pkg::ST_OK;
    case (r.op)
      ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_REAR: begin
        if (held >= DEPTH) rsp.status = ple_pkg::ST_FULL;
        else insert_at((r.op == ple_pkg::OP_ADD_FRONT) ? 0 : held, r.new_element);
      end
      ple_pkg::OP_REM_FRONT, ple_pkg::OP_REM_REAR: begin
        if (held == 0) rsp.status = ple_pkg::ST_UNDERFLOW;
        else rsp.removed_element = take_from((r.op == ple_pkg::OP_REM_FRONT) ? 0 : held - 1);
      end
      ple_pkg::OP_INS_POS: begin
        if (r.position < 1 || r.position > held + 1) rsp.status = ple_pkg::ST_RANGE;
        else if (held >= DEPTH) rsp.status = ple_pkg::ST_FULL;
        else insert_at(r.position - 1, r.new_element);
      end
      ple_pkg::OP_REM_POS: begin
        if (r.position < 1 || r.position > held) rsp.status = ple_pkg::ST_RANGE;
        else rsp.removed_element = take_from(r.position - 1);
      end
      default: ;
    endcase
    rsp.element_count = 5'(held);
    return rsp;
  endfunction

  function automatic void report_mismatch(input string what, input logic [31:0] exp_val,
                                          input logic [31:0] got_val);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_val, got_val);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      expected_rsp.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected word", '0, 32'(out_data_i));
        end else begin
          want = expected_rsp.pop_front();
          words++;
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_data_i.status));
          if (out_data_i.removed_element !== want.removed_element)
            report_mismatch("removed_element", want.removed_element,
                            out_data_i.removed_element);
          if (out_data_i.element_count !== want.element_count)
            report_mismatch("element_count", 32'(want.element_count),
                            32'(out_data_i.element_count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_request(in_data_i);
        case (want.status)
          ple_pkg::ST_FULL:      full_hits++;
          ple_pkg::ST_UNDERFLOW: underflow_hits++;
          ple_pkg::ST_RANGE:     range_hits++;
          default: ;
        endcase
        expected_rsp.push_back(want);
      end
    end
    pending_o        <= expected_rsp.size();
    list_len_o       <= held;
    mismatches_o     <= mismatches;
    words_o          <= words;
    full_hits_o      <= full_hits;
    underflow_hits_o <= underflow_hits;
    range_hits_o     <= range_hits;
  end

  initial begin
    mismatches     = 0;
    words          = 0;
    full_hits      = 0;
    underflow_hits = 0;
    range_hits     = 0;
  end

endmodule

[tb/tb_positional_list_engine.sv]
// Testbench top for the positional list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_positional_list_engine;

  localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
  localparam int unsigned DEPTH        = ple_pkg::DEPTH_DEFAULT;
  localparam int unsigned PHASE_WORDS  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_ready;
  ple_pkg::req_t in_data;
  logic          out_valid;
  logic          out_ready;
  ple_pkg::rsp_t out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned list_len;
  int unsigned words;
  int unsigned full_hits;
  int unsigned underflow_hits;
  int unsigned range_hits;
  int unsigned cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  positional_list_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  ple_list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .list_len_o      (list_len),
    .words_o         (words),
    .full_hits_o     (full_hits),
    .underflow_hits_o(underflow_hits),
    .range_hits_o    (range_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver stalls
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_word(input logic [2:0] op, input logic [4:0] pos,
                           input logic [31:0] value);
    ple_pkg::req_t w;
    w.op          = op;
    w.position    = pos;
    w.new_element = value;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input bit grow);
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] value;
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      op = roll[0] ? OP_SPARE_HI : OP_SPARE_LO;
    end else if (roll < (grow ? 75 : 25)) begin
      case ($urandom_range(0, 2))
        0:       op = ple_pkg::OP_ADD_FRONT;
        1:       op = ple_pkg::OP_ADD_REAR;
        default: op = ple_pkg::OP_INS_POS;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       op = ple_pkg::OP_REM_FRONT;
        1:       op = ple_pkg::OP_REM_REAR;
        default: op = ple_pkg::OP_REM_POS;
      endcase
    end
    span = (op == ple_pkg::OP_INS_POS) ? list_len + 1 : list_len;
    roll = $urandom_range(0, 99);
    if (roll < 80 && span > 0) pos = 5'($urandom_range(1, span));
    else if (roll < 90)        pos = roll[0] ? 5'd0 : 5'(span + 1);
    else                       pos = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 7))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom;
    endcase
    send_word(op, pos, value);
  endtask

  initial begin
    bit          grow;
    int unsigned run_left;
    in_valid    <= 1'b0;
    in_data     <= '0;
    rst_ni      <= 1'b0;
    tx_idle_pct = 37;
    rx_idle_pct = 51;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corners
    send_word(ple_pkg::OP_REM_FRONT, 5'd0, 32'h0);
    send_word(ple_pkg::OP_REM_REAR, 5'd0, 32'h0);
    send_word(ple_pkg::OP_REM_POS, 5'd1, 32'h0);
    send_word(ple_pkg::OP_INS_POS, 5'd0, 32'h1234_5678);
    send_word(ple_pkg::OP_INS_POS, 5'd2, 32'h1234_5678);
    send_word(ple_pkg::OP_INS_POS, 5'd1, 32'hFFFF_FFFF);
    send_word(ple_pkg::OP_ADD_FRONT, 5'd0, 32'h0);
    send_word(ple_pkg::OP_ADD_REAR, 5'd31, 32'h8000_0001);
    send_word(OP_SPARE_LO, 5'd31, 32'hFFFF_FFFF);
    send_word(OP_SPARE_HI, 5'd16, 32'h5A5A_5A5A);
    send_word(ple_pkg::OP_INS_POS, 5'd31, 32'hA5A5_A5A5);
    send_word(ple_pkg::OP_INS_POS, 5'd4, 32'h0000_0004);
    send_word(ple_pkg::OP_REM_POS, 5'd2, 32'h0);
    // fill to capacity
    for (int i = 0; i < DEPTH - 3; i++) begin
      case (i % 3)
        0:       send_word(ple_pkg::OP_ADD_FRONT, 5'd0, $urandom);
        1:       send_word(ple_pkg::OP_ADD_REAR, 5'd0, $urandom);
        default: send_word(ple_pkg::OP_INS_POS, 5'd2, $urandom);
      endcase
    end
    // full list corners: range test wins over full
    send_word(ple_pkg::OP_ADD_REAR, 5'd0, 32'hDEAD_0001);
    send_word(ple_pkg::OP_INS_POS, 5'd18, 32'hDEAD_0002);
    send_word(ple_pkg::OP_INS_POS, 5'd17, 32'hDEAD_0003);
    send_word(ple_pkg::OP_REM_POS, 5'd17, 32'h0);
    send_word(ple_pkg::OP_REM_POS, 5'd16, 32'h0);
    send_word(ple_pkg::OP_REM_POS, 5'd1, 32'h0);
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 37; rx_idle_pct = 51; end
        1:       begin tx_idle_pct = 51; rx_idle_pct = 37; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      grow     = 1'b1;
      run_left = $urandom_range(20, 60);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (run_left == 0) begin
          grow     = !grow;
          run_left = $urandom_range(20, 60);
        end
        run_left--;
        send_random(grow);
      end
      wait_for_results();
    end

    repeat (40) @(posedge clk_i);
    $display("checked %0d result words; rejects seen: %0d full, %0d underflow, %0d range",
             words, full_hits, underflow_hits, range_hits);
    $display("idle mixes covered: sender-heavy, receiver-heavy and back-to-back");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
